// ===== rtl/greedy_box_nms_macros.svh =====
// Assertion macros used by the checker file of the greedy box NMS block.
// Depends on nothing; each macro expects clk and rst_n in scope.
`ifndef GREEDY_BOX_NMS_MACROS_SVH
`define GREEDY_BOX_NMS_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define GBN_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define GBN_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/gbn_pkg.sv =====
// Shared constants, types and helper functions of the greedy box NMS block.
// Depends on nothing; imported by the top level, the controller and the datapath.
package gbn_pkg;

  localparam int MAX_KEEP = 64;
  localparam int SLOT_W   = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
  localparam int CNT_W    = $clog2(MAX_KEEP + 1);
  localparam int LIM_W    = 7;
  localparam int CMP_W    = (CNT_W > LIM_W) ? CNT_W : LIM_W;
  localparam int COORD_W  = 16;
  localparam int AREA_W   = 2 * COORD_W;
  localparam int THR_W    = 17;
  localparam int OUT_SLOT_W = 6;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_IOU_THRESHOLD = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_KEEP_LIMIT    = CFG_IDX_W'(1);

  localparam logic [THR_W-1:0] THR_RESET   = THR_W'(29491);
  localparam logic [LIM_W-1:0] LIMIT_RESET = LIM_W'(64);

  typedef struct packed {
    logic              load;
    logic              rd_en;
    logic [SLOT_W-1:0] rd_addr;
    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;
  } gbn_cmd_t;

  typedef struct packed {
    logic busy;
    logic hit;
  } gbn_sts_t;

  function automatic logic [COORD_W-1:0] span16(input logic [COORD_W-1:0] lo,
                                                input logic [COORD_W-1:0] hi);
    return (hi >= lo) ? (hi - lo) : '0;
  endfunction

endpackage

// ===== rtl/greedy_box_nms.sv =====
// Top level of the greedy box NMS block: configuration registers, controller
// and datapath. Depends on gbn_pkg, gbn_ctrl and gbn_datapath.
//
// Boxes arrive sorted by descending score; in_set_start opens a new set. Each
// box yields one result beat. The kept-box store has a single read port, so
// the kept boxes of the set stream out one per cycle into a six-stage IoU
// compare pipeline, which is then drained before the decision; the result is
// registered as the controller leaves S_DONE, which also frees the input. A
// box that meets an empty kept list or a closed set goes straight to S_DONE.
// Only one box is in flight at a time, but a finished result may wait in the
// output register while the next box is accepted; a result still waiting
// there holds the next box in S_DONE. The stores have no reset and need no
// clearing pass. Configuration beats are always taken and must only be sent
// while idle.
module greedy_box_nms (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_set_start,
  input  logic [15:0] in_box_xmin,
  input  logic [15:0] in_box_ymin,
  input  logic [15:0] in_box_xmax,
  input  logic [15:0] in_box_ymax,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_kept,
  output logic [5:0]  out_keep_slot,
  output logic        out_limit_reached,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [16:0] cfg_data
);
  import gbn_pkg::*;

  logic [THR_W-1:0] iou_threshold_r;
  logic [LIM_W-1:0] keep_limit_r;
  gbn_cmd_t         cmd;
  gbn_sts_t         sts;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iou_threshold_r <= THR_RESET;
      keep_limit_r    <= LIMIT_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_IOU_THRESHOLD: iou_threshold_r <= cfg_data;
        CFG_KEEP_LIMIT:    keep_limit_r    <= cfg_data[LIM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  gbn_ctrl u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_set_start      (in_set_start),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_kept          (out_kept),
    .out_keep_slot     (out_keep_slot),
    .out_limit_reached (out_limit_reached),
    .keep_limit        (keep_limit_r),
    .cmd               (cmd),
    .sts               (sts)
  );

  gbn_datapath u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .iou_threshold (iou_threshold_r),
    .in_box_xmin   (in_box_xmin),
    .in_box_ymin   (in_box_ymin),
    .in_box_xmax   (in_box_xmax),
    .in_box_ymax   (in_box_ymax)
  );

endmodule

// ===== rtl/gbn_datapath.sv =====
// Datapath of the greedy box NMS block: kept-box and area stores and the
// pipelined IoU compare. Depends on gbn_pkg; driven by gbn_ctrl commands.
module gbn_datapath (
  input  logic                     clk,
  input  logic                     rst_n,
  input  gbn_pkg::gbn_cmd_t        cmd,
  output gbn_pkg::gbn_sts_t        sts,
  input  logic [16:0]              iou_threshold,
  input  logic [15:0]              in_box_xmin,
  input  logic [15:0]              in_box_ymin,
  input  logic [15:0]              in_box_xmax,
  input  logic [15:0]              in_box_ymax
);
  import gbn_pkg::*;

  logic [4*COORD_W-1:0] boxes_mem [MAX_KEEP];
  logic [AREA_W-1:0]    areas_mem [MAX_KEEP];

  logic [COORD_W-1:0] x0_r, y0_r, x1_r, y1_r;
  logic [AREA_W-1:0]  area_r;

  logic                 v1_r, v2_r, v3_r, v4_r, v5_r;
  logic                 hit_r;
  logic [4*COORD_W-1:0] rbox_r;
  logic [AREA_W-1:0]    rarea_r;
  logic [COORD_W-1:0]   iw_r, ih_r;
  logic [AREA_W-1:0]    karea2_r, karea3_r;
  logic [AREA_W-1:0]    inter3_r, inter4_r, inter5_r;
  logic [AREA_W:0]      uni4_r;
  logic [THR_W+THR_W-1:0] plo_r;
  logic [THR_W+AREA_W-THR_W:0] phi_r;

  logic [COORD_W-1:0] bx0, by0, bx1, by1;
  logic [THR_W+AREA_W:0] rhs;
  logic [AREA_W+COORD_W-1:0] lhs;

  assign bx0 = rbox_r[COORD_W-1:0];
  assign by0 = rbox_r[2*COORD_W-1:COORD_W];
  assign bx1 = rbox_r[3*COORD_W-1:2*COORD_W];
  assign by1 = rbox_r[4*COORD_W-1:3*COORD_W];

  assign rhs = {phi_r, {THR_W{1'b0}}} + (THR_W + AREA_W + 1)'(plo_r);
  assign lhs = {inter5_r, {COORD_W{1'b0}}};

  assign sts.busy = v1_r | v2_r | v3_r | v4_r | v5_r;
  assign sts.hit  = hit_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x0_r   <= in_box_xmin;
      y0_r   <= in_box_ymin;
      x1_r   <= in_box_xmax;
      y1_r   <= in_box_ymax;
      area_r <= span16(in_box_xmin, in_box_xmax) * span16(in_box_ymin, in_box_ymax);
    end
    if (cmd.wr_en) begin
      boxes_mem[cmd.wr_addr] <= {y1_r, x1_r, y0_r, x0_r};
      areas_mem[cmd.wr_addr] <= area_r;
    end
    if (cmd.rd_en) begin
      rbox_r  <= boxes_mem[cmd.rd_addr];
      rarea_r <= areas_mem[cmd.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    iw_r     <= span16((x0_r > bx0) ? x0_r : bx0, (x1_r < bx1) ? x1_r : bx1);
    ih_r     <= span16((y0_r > by0) ? y0_r : by0, (y1_r < by1) ? y1_r : by1);
    karea2_r <= rarea_r;
    inter3_r <= iw_r * ih_r;
    karea3_r <= karea2_r;
    uni4_r   <= {1'b0, area_r} + {1'b0, karea3_r} - {1'b0, inter3_r};
    inter4_r <= inter3_r;
    plo_r    <= iou_threshold * uni4_r[THR_W-1:0];
    phi_r    <= iou_threshold * uni4_r[AREA_W:THR_W];
    inter5_r <= inter4_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      v3_r  <= 1'b0;
      v4_r  <= 1'b0;
      v5_r  <= 1'b0;
      hit_r <= 1'b0;
    end else begin
      v1_r <= cmd.rd_en;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      if (cmd.load) begin
        hit_r <= 1'b0;
      end else if (v5_r && ((THR_W + AREA_W + 1)'(lhs) > rhs)) begin
        hit_r <= 1'b1;
      end
    end
  end

endmodule

// ===== rtl/gbn_ctrl.sv =====
// Controller of the greedy box NMS block: sequences the scan of kept boxes,
// tracks the kept count and holds the result register. Depends on gbn_pkg.
module gbn_ctrl (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     in_set_start,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     out_kept,
  output logic [5:0]               out_keep_slot,
  output logic                     out_limit_reached,
  input  logic [6:0]               keep_limit,
  output gbn_pkg::gbn_cmd_t        cmd,
  input  gbn_pkg::gbn_sts_t        sts
);
  import gbn_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DRAIN, S_DONE} state_t;

  state_t           state_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] idx_r;
  logic             closed_r;
  logic             reject_r;
  logic             out_valid_r;
  logic             out_kept_r;
  logic [OUT_SLOT_W-1:0] out_slot_r;
  logic             out_limit_r;

  logic [CMP_W-1:0] lim_wide;
  logic [CNT_W-1:0] lim;
  logic [CNT_W-1:0] cnt_eff;
  logic             closed_eff;
  logic             accept;
  logic             slot_free;
  logic [CNT_W:0]   count_inc;

  always_comb begin
    lim_wide = CMP_W'(keep_limit);
    if (lim_wide == '0) begin
      lim_wide = CMP_W'(1);
    end else if (lim_wide > CMP_W'(MAX_KEEP)) begin
      lim_wide = CMP_W'(MAX_KEEP);
    end
  end

  assign lim        = CNT_W'(lim_wide);
  assign cnt_eff    = in_set_start ? '0 : count_r;
  assign closed_eff = (!in_set_start && closed_r) || (cnt_eff >= lim);
  assign in_ready   = (state_r == S_IDLE);
  assign accept     = in_valid && in_ready;
  assign slot_free  = !out_valid_r || out_ready;
  assign count_inc  = {1'b0, count_r} + (CNT_W + 1)'(1);

  assign cmd.load    = accept;
  assign cmd.rd_en   = (state_r == S_SCAN);
  assign cmd.rd_addr = idx_r[SLOT_W-1:0];
  assign cmd.wr_en   = (state_r == S_DONE) && slot_free && !reject_r && !sts.hit;
  assign cmd.wr_addr = count_r[SLOT_W-1:0];

  assign out_valid         = out_valid_r;
  assign out_kept          = out_kept_r;
  assign out_keep_slot     = out_slot_r;
  assign out_limit_reached = out_limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      idx_r       <= '0;
      closed_r    <= 1'b0;
      reject_r    <= 1'b0;
      out_valid_r <= 1'b0;
      out_kept_r  <= 1'b0;
      out_slot_r  <= '0;
      out_limit_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            count_r  <= cnt_eff;
            closed_r <= closed_eff;
            reject_r <= closed_eff;
            idx_r    <= '0;
            if (closed_eff || (cnt_eff == '0)) begin
              state_r <= S_DONE;
            end else begin
              state_r <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (idx_r == count_r - CNT_W'(1)) begin
            state_r <= S_DRAIN;
          end else begin
            idx_r <= idx_r + CNT_W'(1);
          end
        end
        S_DRAIN: begin
          if (!sts.busy) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (slot_free) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
            if (reject_r) begin
              out_kept_r  <= 1'b0;
              out_slot_r  <= '0;
              out_limit_r <= 1'b1;
            end else if (sts.hit) begin
              out_kept_r  <= 1'b0;
              out_slot_r  <= '0;
              out_limit_r <= 1'b0;
            end else begin
              out_kept_r  <= 1'b1;
              out_slot_r  <= OUT_SLOT_W'(count_r);
              out_limit_r <= (count_inc >= {1'b0, lim});
              closed_r    <= (count_inc >= {1'b0, lim});
              count_r     <= CNT_W'(count_inc);
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/gbn_checker.sv =====
// Port-level checker of the greedy box NMS block, bound to the top level.
// Depends on greedy_box_nms_macros.svh.
`include "greedy_box_nms_macros.svh"

module gbn_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_kept,
  input logic [5:0] out_keep_slot,
  input logic       out_limit_reached
);

  `GBN_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_keep_slot) && $stable(out_kept) && $stable(out_limit_reached), "Stalled result beat changed.")
  `GBN_ASSERT_NOW(a_drop_slot, out_valid && !out_kept, out_keep_slot == 6'd0, "Rejected box carries a nonzero slot.")
  `GBN_ASSERT_NEXT(a_one_box, in_valid && in_ready, !in_ready, "Second box accepted while one is in flight.")

endmodule

bind greedy_box_nms gbn_checker u_gbn_checker (.*);
